/* hdl/colfit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colville fitness package
// Shared widths, field offsets, sequencer codes and helpers for the Colville
// fitness and best-two selection block.
// ----------------------------------------------------------------------------
package colfit_pkg;

  localparam int unsigned POP_MAX_DEF   = 2048;
  localparam int unsigned FRAC_BITS_DEF = 10;

  localparam int unsigned CHROM_W     = 64;
  localparam int unsigned FIT_W       = 52;
  localparam int unsigned IDX_W       = 11;
  localparam int unsigned OUT_TDATA_W = 128;

  // Output tdata layout, lowest bit first
  localparam int unsigned FIT_LSB  = 0;
  localparam int unsigned BIDX_LSB = FIT_LSB + FIT_W;     // 52
  localparam int unsigned SIDX_LSB = BIDX_LSB + IDX_W;    // 63
  localparam int unsigned BFIT_LSB = SIDX_LSB + IDX_W;    // 74
  localparam int unsigned STAG_BIT = BFIT_LSB + FIT_W;    // 126

  localparam logic [FIT_W-1:0] THRESH_RST = FIT_W'(105);

  // Shared multiplier and accumulator
  localparam int unsigned MUL_W = 34;
  localparam int unsigned PRD_W = 2 * MUL_W;
  localparam int unsigned ACC_W = 75;
  localparam int unsigned HALF_SH = 34;

  localparam int unsigned K_YX   = 1000;
  localparam int unsigned K_ZW   = 900;
  localparam int unsigned K_LIN  = 10;
  localparam int unsigned K_OFS  = 101;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_FIT  = 5'b00100,
    ST_SEL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  // One code per multiplier slot of the fitness sequence
  typedef enum logic [3:0] {
    STEP_XSQ  = 4'd0,
    STEP_WSQ  = 4'd1,
    STEP_ASQ  = 4'd2,
    STEP_BSQ  = 4'd3,
    STEP_ALO  = 4'd4,
    STEP_AHI  = 4'd5,
    STEP_BLO  = 4'd6,
    STEP_BHI  = 4'd7,
    STEP_UX   = 4'd8,
    STEP_UW   = 4'd9,
    STEP_VY   = 4'd10,
    STEP_M10  = 4'd11,
    STEP_VZ   = 4'd12,
    STEP_SUM  = 4'd13,
    STEP_M101 = 4'd14,
    STEP_LAST = 4'd15
  } step_e;

  // Magnitude of a 33-bit signed value
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n : v;
  endfunction

endpackage

/* hdl/colville_fitness_top_two_select_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colville fitness with best-two selection
// Scores each chromosome with ten times the Colville function on a shared
// multiplier and tracks the two lowest scores of a generation.
// ----------------------------------------------------------------------------
// One chromosome is scored at a time; its sequence of 14 products runs
//   through the single 34x34 multiplier.
// s_axis_tready is high only while idle; a finished result waits in the
//   output register, and the next chromosome is taken meanwhile.
// Reset (rst_ni low, asynchronous): sequencer idle, output empty, selection
//   state cleared, stagnation threshold back to 105.
module colville_fitness_top_two_select_top #(
  parameter int unsigned POP_MAX   = colfit_pkg::POP_MAX_DEF,
  parameter int unsigned FRAC_BITS = colfit_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // stagnation_threshold register
  input  logic                               cfg_we_i,
  input  logic [colfit_pkg::FIT_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [colfit_pkg::CHROM_W-1:0]     s_axis_tdata,  // [63:0] chromosome
  input  logic                               s_axis_tlast,  // last_of_generation
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [51:0] fitness_scaled, [62:52] best_index, [73:63] second_index,
  // [125:74] best_fitness, [126] stagnant, [127] zero
  output logic [colfit_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                               m_axis_tuser   // generation_done
);

  localparam int unsigned FIT_W = colfit_pkg::FIT_W;
  localparam int unsigned IDX_W = colfit_pkg::IDX_W;
  localparam int unsigned MUL_W = colfit_pkg::MUL_W;
  localparam int unsigned PRD_W = colfit_pkg::PRD_W;
  localparam int unsigned ACC_W = colfit_pkg::ACC_W;
  localparam int unsigned SH_W  = ACC_W + 20;
  localparam int unsigned IDX_MAX = (1 << IDX_W) - 1;
  localparam int unsigned POS_LIM_I = (POP_MAX - 1 < IDX_MAX) ? POP_MAX - 1 : IDX_MAX;
  localparam logic [IDX_W-1:0] POS_LIMIT = IDX_W'(POS_LIM_I);
  // Fixed-point one, 2^FRAC_BITS
  localparam logic signed [32:0] ONE_S = 33'sd1 <<< FRAC_BITS;

  colfit_pkg::state_e state_q, state_d;
  colfit_pkg::step_e  step_q, step_d;

  logic [FIT_W-1:0] thr_q;

  // Item being scored
  logic [colfit_pkg::CHROM_W-1:0] chrom_q;
  logic                           last_q;

  // Datapath registers
  logic [PRD_W-1:0] p_q;
  logic [30:0]      xsq_q, xsq_d, wsq_q, wsq_d;
  logic [62:0]      a2_q, a2_d, b2_q, b2_d;
  logic [MUL_W-1:0] s_q, s_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [FIT_W-1:0] fit_q, fit_d;

  // Selection state
  logic [IDX_W-1:0] pos_q;
  logic [FIT_W-1:0] low_v_q, run_v_q;
  logic [IDX_W-1:0] low_p_q, run_p_q;
  logic             run_ok_q;

  // Output register
  logic                               out_valid_q;
  logic [colfit_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                               out_user_q;

  logic in_xfer, out_free, out_load;

  assign s_axis_tready = (state_q == colfit_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = (state_q == colfit_pkg::ST_OUT) && out_free;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // --------------------------------------------------------------------------
  // Decode: raw code minus 32768 is the code with its top bit flipped
  // --------------------------------------------------------------------------
  logic signed [32:0] xv, yv, wv, zv;
  logic signed [32:0] a_s, b_s, ux_s, uw_s, vy_s, vz_s;
  logic [32:0]        x_mag, w_mag, a_mag, b_mag, ux_mag, uw_mag, vy_mag, vz_mag;

  always_comb begin
    xv = 33'($signed({~chrom_q[63], chrom_q[62:48]}));
    yv = 33'($signed({~chrom_q[47], chrom_q[46:32]}));
    wv = 33'($signed({~chrom_q[31], chrom_q[30:16]}));
    zv = 33'($signed({~chrom_q[15], chrom_q[14:0]}));
    // y*one - x^2 and z*one - w^2, magnitude at most 2^31
    a_s  = (yv <<< FRAC_BITS) - $signed({2'b00, xsq_q});
    b_s  = (zv <<< FRAC_BITS) - $signed({2'b00, wsq_q});
    ux_s = ONE_S - xv;
    uw_s = ONE_S - wv;
    vy_s = yv - ONE_S;
    vz_s = zv - ONE_S;
    x_mag  = colfit_pkg::mag33(xv);
    w_mag  = colfit_pkg::mag33(wv);
    a_mag  = colfit_pkg::mag33(a_s);
    b_mag  = colfit_pkg::mag33(b_s);
    ux_mag = colfit_pkg::mag33(ux_s);
    uw_mag = colfit_pkg::mag33(uw_s);
    vy_mag = colfit_pkg::mag33(vy_s);
    vz_mag = colfit_pkg::mag33(vz_s);
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: operand select per step, product registered
  // --------------------------------------------------------------------------
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [PRD_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      colfit_pkg::STEP_XSQ:  begin mul_a = MUL_W'(x_mag[16:0]);  mul_b = MUL_W'(x_mag[16:0]); end
      colfit_pkg::STEP_WSQ:  begin mul_a = MUL_W'(w_mag[16:0]);  mul_b = MUL_W'(w_mag[16:0]); end
      colfit_pkg::STEP_ASQ:  begin mul_a = MUL_W'(a_mag[31:0]);  mul_b = MUL_W'(a_mag[31:0]); end
      colfit_pkg::STEP_BSQ:  begin mul_a = MUL_W'(b_mag[31:0]);  mul_b = MUL_W'(b_mag[31:0]); end
      colfit_pkg::STEP_ALO:  begin
        mul_a = a2_q[MUL_W-1:0];
        mul_b = MUL_W'(colfit_pkg::K_YX);
      end
      colfit_pkg::STEP_AHI:  begin
        mul_a = MUL_W'(a2_q[62:MUL_W]);
        mul_b = MUL_W'(colfit_pkg::K_YX);
      end
      colfit_pkg::STEP_BLO:  begin
        mul_a = b2_q[MUL_W-1:0];
        mul_b = MUL_W'(colfit_pkg::K_ZW);
      end
      colfit_pkg::STEP_BHI:  begin
        mul_a = MUL_W'(b2_q[62:MUL_W]);
        mul_b = MUL_W'(colfit_pkg::K_ZW);
      end
      colfit_pkg::STEP_UX:   begin mul_a = MUL_W'(ux_mag[16:0]); mul_b = MUL_W'(ux_mag[16:0]); end
      colfit_pkg::STEP_UW:   begin mul_a = MUL_W'(uw_mag[16:0]); mul_b = MUL_W'(uw_mag[16:0]); end
      colfit_pkg::STEP_VY:   begin mul_a = MUL_W'(vy_mag[16:0]); mul_b = MUL_W'(vy_mag[16:0]); end
      colfit_pkg::STEP_M10:  begin mul_a = s_q; mul_b = MUL_W'(colfit_pkg::K_LIN); end
      colfit_pkg::STEP_VZ:   begin mul_a = MUL_W'(vz_mag[16:0]); mul_b = MUL_W'(vz_mag[16:0]); end
      colfit_pkg::STEP_SUM:  begin mul_a = '0; mul_b = '0; end
      colfit_pkg::STEP_M101: begin mul_a = s_q; mul_b = MUL_W'(colfit_pkg::K_OFS); end
      colfit_pkg::STEP_LAST: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // --------------------------------------------------------------------------
  // Consume the product of the previous step
  // --------------------------------------------------------------------------
  always_comb begin
    xsq_d = xsq_q;
    wsq_d = wsq_q;
    a2_d  = a2_q;
    b2_d  = b2_q;
    s_d   = s_q;
    acc_d = acc_q;
    if (state_q == colfit_pkg::ST_CALC) begin
      unique case (step_q)
        colfit_pkg::STEP_XSQ:  ;
        colfit_pkg::STEP_WSQ:  xsq_d = p_q[30:0];
        colfit_pkg::STEP_ASQ:  wsq_d = p_q[30:0];
        colfit_pkg::STEP_BSQ:  a2_d  = p_q[62:0];
        colfit_pkg::STEP_ALO:  b2_d  = p_q[62:0];
        colfit_pkg::STEP_AHI:  acc_d = ACC_W'(p_q);
        colfit_pkg::STEP_BLO:  acc_d = acc_q + (ACC_W'(p_q) << colfit_pkg::HALF_SH);
        colfit_pkg::STEP_BHI:  acc_d = acc_q + ACC_W'(p_q);
        colfit_pkg::STEP_UX:   acc_d = acc_q + (ACC_W'(p_q) << colfit_pkg::HALF_SH);
        colfit_pkg::STEP_UW:   s_d   = p_q[MUL_W-1:0];
        colfit_pkg::STEP_VY:   s_d   = s_q + p_q[MUL_W-1:0];
        colfit_pkg::STEP_M10:  s_d   = p_q[MUL_W-1:0];
        colfit_pkg::STEP_VZ:   acc_d = acc_q + (ACC_W'(p_q) << (2 * FRAC_BITS));
        colfit_pkg::STEP_SUM:  s_d   = s_q + p_q[MUL_W-1:0];
        colfit_pkg::STEP_M101: ;
        colfit_pkg::STEP_LAST: acc_d = acc_q + (ACC_W'(p_q) << (2 * FRAC_BITS));
      endcase
    end
  end

  // Drop to 20 fractional bits (4*FRAC_BITS in the sum), saturate at 52 bits
  logic [SH_W-1:0] fit_sh;
  always_comb begin
    fit_sh = {acc_q, 20'b0} >> (4 * FRAC_BITS);
    fit_d  = (|fit_sh[SH_W-1:FIT_W]) ? '1 : fit_sh[FIT_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      colfit_pkg::ST_IDLE: begin
        step_d = colfit_pkg::STEP_XSQ;
        if (in_xfer) state_d = colfit_pkg::ST_CALC;
      end
      colfit_pkg::ST_CALC: begin
        step_d = colfit_pkg::step_e'(step_q + 4'd1);
        if (step_q == colfit_pkg::STEP_LAST) state_d = colfit_pkg::ST_FIT;
      end
      colfit_pkg::ST_FIT:  state_d = colfit_pkg::ST_SEL;
      colfit_pkg::ST_SEL:  state_d = colfit_pkg::ST_OUT;
      colfit_pkg::ST_OUT: begin
        if (out_free) state_d = colfit_pkg::ST_IDLE;
      end
      default: state_d = colfit_pkg::ST_IDLE;
    endcase
  end

  // Result word: fitness on every item; selection fields zero except on the last item of a generation
  logic [FIT_W-1:0] gap;
  always_comb begin
    gap        = run_ok_q ? (run_v_q - low_v_q) : '0;
    out_data_d = '0;
    out_data_d[colfit_pkg::FIT_LSB +: FIT_W] = fit_q;
    if (last_q) begin
      out_data_d[colfit_pkg::BIDX_LSB +: IDX_W] = low_p_q;
      out_data_d[colfit_pkg::SIDX_LSB +: IDX_W] = run_ok_q ? run_p_q : low_p_q;
      out_data_d[colfit_pkg::BFIT_LSB +: FIT_W] = low_v_q;
      out_data_d[colfit_pkg::STAG_BIT]          = (gap < thr_q);
    end
  end

  // --------------------------------------------------------------------------
  // Control and selection registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= colfit_pkg::ST_IDLE;
      step_q      <= colfit_pkg::STEP_XSQ;
      thr_q       <= colfit_pkg::THRESH_RST;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      low_v_q     <= '1;
      low_p_q     <= '0;
      run_v_q     <= '1;
      run_p_q     <= '0;
      run_ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // Strict compares keep the first-seen item on ties
      if (state_q == colfit_pkg::ST_SEL) begin
        if (pos_q == '0) begin
          low_v_q  <= fit_q;
          low_p_q  <= '0;
          run_ok_q <= 1'b0;
        end else if (fit_q < low_v_q) begin
          run_v_q  <= low_v_q;
          run_p_q  <= low_p_q;
          run_ok_q <= 1'b1;
          low_v_q  <= fit_q;
          low_p_q  <= pos_q;
        end else if (!run_ok_q || fit_q < run_v_q) begin
          run_v_q  <= fit_q;
          run_p_q  <= pos_q;
          run_ok_q <= 1'b1;
        end
        if (pos_q < POS_LIMIT) pos_q <= pos_q + 1'b1;
      end

      // Start a fresh generation once the report is loaded into the output register
      if (out_load && last_q) begin
        pos_q    <= '0;
        low_v_q  <= '1;
        low_p_q  <= '0;
        run_v_q  <= '1;
        run_p_q  <= '0;
        run_ok_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      chrom_q <= s_axis_tdata;
      last_q  <= s_axis_tlast;
    end
    if (state_q == colfit_pkg::ST_CALC) p_q <= mul_p;
    xsq_q <= xsq_d;
    wsq_q <= wsq_d;
    a2_q  <= a2_d;
    b2_q  <= b2_d;
    s_q   <= s_d;
    acc_q <= acc_d;
    if (state_q == colfit_pkg::ST_FIT) fit_q <= fit_d;
    if (out_load) begin
      out_data_q <= out_data_d;
      out_user_q <= last_q;
    end
  end

endmodule

/* hdl/colfit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colville fitness port checker
// Watches the stream ports of the fitness block over time.
// ----------------------------------------------------------------------------
module colfit_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [colfit_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                               m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // One chromosome at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while scoring");

  // Selection fields stay zero inside a generation
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[colfit_pkg::OUT_TDATA_W-1:colfit_pkg::BIDX_LSB] == '0)
    else $error("selection fields set before generation end");

  // The best of a generation cannot exceed its own last score
  a_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[colfit_pkg::BFIT_LSB +: colfit_pkg::FIT_W] <=
      m_axis_tdata[colfit_pkg::FIT_LSB +: colfit_pkg::FIT_W])
    else $error("best fitness above last fitness");

endmodule

bind colville_fitness_top_two_select_top colfit_checker u_colfit_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/tb_colville_fitness_top_two_select_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colville fitness and best-two selection testbench
// Streams chromosomes in generations through the block, predicts every score
// and every generation summary, and compares each result transfer field by
// field. Covers directed corners, threshold limits, random generations under
// sender bursts and receiver stalls, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_colville_fitness_top_two_select_top;

  localparam int unsigned FIT_W       = colfit_pkg::FIT_W;
  localparam int unsigned IDX_W       = colfit_pkg::IDX_W;
  localparam int unsigned CHROM_W     = colfit_pkg::CHROM_W;
  localparam int unsigned OUT_TDATA_W = colfit_pkg::OUT_TDATA_W;
  localparam int unsigned POP_MAX_DEF = colfit_pkg::POP_MAX_DEF;
  localparam int unsigned FIT_LSB     = colfit_pkg::FIT_LSB;
  localparam int unsigned BIDX_LSB    = colfit_pkg::BIDX_LSB;
  localparam int unsigned SIDX_LSB    = colfit_pkg::SIDX_LSB;
  localparam int unsigned BFIT_LSB    = colfit_pkg::BFIT_LSB;
  localparam int unsigned STAG_BIT    = colfit_pkg::STAG_BIT;
  localparam logic [FIT_W-1:0] THRESH_RST = colfit_pkg::THRESH_RST;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int FB             = int'(colfit_pkg::FRAC_BITS_DEF);
  localparam int HOLD_OFF       = 400;   // long receiver hold-off, in cycles
  localparam int TAIL_CYCLES    = 40;
  // Longest correct quiet stretch is the hold-off; allow a wide margin.
  localparam int QUIET_LIMIT    = 5000;
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_ITEMS   = 230;   // per random phase, five phases

  localparam logic [FIT_W-1:0]   FIT_MASK = '1;
  localparam logic [IDX_W-1:0]   POS_CAP  = (POP_MAX_DEF - 1 < 2047) ?
                                            IDX_W'(POP_MAX_DEF - 1) : IDX_W'(2047);
  localparam logic [15:0]        OPT_CODE = 16'h8400;  // decodes to 1.0
  localparam logic [CHROM_W-1:0] OPT_CHROM = {4{OPT_CODE}};

  typedef struct packed {
    logic [FIT_W-1:0] fitness;
    logic             gen_done;
    logic [IDX_W-1:0] best_idx;
    logic [IDX_W-1:0] second_idx;
    logic [FIT_W-1:0] best_fit;
    logic             stagnant;
  } fit_result_t;

  // DUT ports
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [FIT_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [CHROM_W-1:0]     s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  // Predictor state, at its reset values
  logic [FIT_W-1:0] thr_model = THRESH_RST;
  logic [IDX_W-1:0] gen_pos   = '0;
  logic [FIT_W-1:0] lo_val    = '1;
  logic [IDX_W-1:0] lo_pos    = '0;
  logic [FIT_W-1:0] run_val   = '1;
  logic [IDX_W-1:0] run_pos   = '0;
  logic             run_ok    = 1'b0;

  fit_result_t results_due[$];
  fit_result_t due;
  int          mismatch_cnt = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;

  // Traffic shaping
  int           gap_max    = 0;
  int           burst_max  = 1;
  int           burst_left = 0;
  logic [15:0]  rx_mask    = '1;
  logic [3:0]   rx_phase   = '0;
  int           rx_hold_left = 0;
  logic [63:0]  prev_chrom = '0;
  event         hold_off_ev;

  always #CLK_HALF clk_i = ~clk_i;

  colville_fitness_top_two_select_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // Score arithmetic: exact square of a value up to 2^31 in magnitude
  // --------------------------------------------------------------------------
  function automatic logic [127:0] mag_sq(input longint v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    return {64'd0, m} * {64'd0, m};
  endfunction

  // Ten times the Colville value, 4*FB fractional bits cut down to 20
  function automatic logic [FIT_W-1:0] colville_score(input logic [CHROM_W-1:0] c);
    longint      x, y, w, z, one, a, b;
    logic [127:0] lin, acc;
    x   = longint'({48'd0, c[63:48]}) - 32768;
    y   = longint'({48'd0, c[47:32]}) - 32768;
    w   = longint'({48'd0, c[31:16]}) - 32768;
    z   = longint'({48'd0, c[15:0]})  - 32768;
    one = longint'(1) << FB;
    a   = y * one - x * x;
    b   = z * one - w * w;
    lin = 128'd10 * (mag_sq(one - x) + mag_sq(one - w))
        + 128'd101 * (mag_sq(y - one) + mag_sq(z - one));
    acc = mag_sq(a) * 128'd1000 + mag_sq(b) * 128'd900 + (lin << (2 * FB));
    if (4 * FB >= 20) begin
      acc = acc >> (4 * FB - 20);
    end else begin
      acc = acc << (20 - 4 * FB);
    end
    return (acc > {76'd0, FIT_MASK}) ? FIT_MASK : acc[FIT_W-1:0];
  endfunction

  // Advance the best-two tracker by one chromosome and form its result
  function automatic fit_result_t predict_result(input logic [CHROM_W-1:0] chrom,
                                                 input logic end_of_gen);
    fit_result_t      r;
    logic [FIT_W-1:0] v;
    logic [FIT_W-1:0] gap;
    v = colville_score(chrom);
    r = '0;
    r.fitness = v;
    if (gen_pos == '0) begin
      lo_val = v;
      lo_pos = '0;
      run_ok = 1'b0;
    end else if (v < lo_val) begin
      // new best: old best drops to runner-up
      run_val = lo_val;
      run_pos = lo_pos;
      run_ok  = 1'b1;
      lo_val  = v;
      lo_pos  = gen_pos;
    end else if (!run_ok || v < run_val) begin
      run_val = v;
      run_pos = gen_pos;
      run_ok  = 1'b1;
    end
    if (gen_pos < POS_CAP) gen_pos++;
    if (end_of_gen) begin
      gap          = run_ok ? run_val - lo_val : '0;
      r.gen_done   = 1'b1;
      r.best_idx   = lo_pos;
      r.second_idx = run_ok ? run_pos : lo_pos;
      r.best_fit   = lo_val;
      r.stagnant   = gap < thr_model;
      gen_pos = '0;
      lo_val  = '1;
      lo_pos  = '0;
      run_val = '1;
      run_pos = '0;
      run_ok  = 1'b0;
    end
    return r;
  endfunction

  // Random chromosome: 0 fully random, 1 near the optimum, 2 field extremes.
  // Repeat the previous one now and then to create ties.
  function automatic logic [CHROM_W-1:0] rand_chromosome(input int flavor);
    logic [CHROM_W-1:0] c;
    if ($urandom_range(0, 5) == 0) return prev_chrom;
    c = {$urandom, $urandom};
    for (int f = 0; f < 4; f++) begin
      if (flavor == 1) begin
        c[f*16 +: 16] = 16'(32'(OPT_CODE) + $urandom_range(0, 8) - 4);
      end else if (flavor == 2) begin
        case ($urandom_range(0, 4))
          0: c[f*16 +: 16] = 16'h0000;
          1: c[f*16 +: 16] = 16'hFFFF;
          2: c[f*16 +: 16] = 16'h8000;
          3: c[f*16 +: 16] = OPT_CODE;
          default: ;
        endcase
      end
    end
    prev_chrom = c;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------
  task automatic set_traffic(input int gmax, input int bmax, input logic [15:0] mask);
    gap_max    = gmax;
    burst_max  = bmax;
    burst_left = 0;
    rx_mask   <= mask;
  endtask

  // Offer one chromosome, hold it until the transfer, then record the
  // expected result. Valid stays high inside a burst.
  task automatic send_chromosome(input logic [CHROM_W-1:0] chrom, input logic end_of_gen);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= chrom;
    s_axis_tlast  <= end_of_gen;
    do @(posedge clk_i); while (!s_axis_tready);
    results_due.push_back(predict_result(chrom, end_of_gen));
  endtask

  // Drop valid and pause until every expected result has come back
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  // Write the stagnation threshold; only called while the block is idle
  task automatic write_threshold(input logic [FIT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    thr_model = value;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_cnt < MAX_REPORTS) begin
      $display("mismatch on result %0d, %s: got %0h, want %0h",
               results_seen, what, got, want);
    end
    mismatch_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall on a rotating mask, or hold off entirely when asked.
  // The hold-off is counted here, not in the test.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left  <= rx_hold_left - 1;
    end else begin
      m_axis_tready <= rx_mask[rx_phase];
    end
    rx_phase <= rx_phase + 4'd1;
  end

  always @(hold_off_ev) rx_hold_left <= HOLD_OFF;

  // --------------------------------------------------------------------------
  // Result checker: compare each transfer with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
      end else begin
        due = results_due.pop_front();
        if (m_axis_tdata[FIT_LSB +: FIT_W] !== due.fitness)
          report_mismatch("fitness_scaled", m_axis_tdata[FIT_LSB +: FIT_W], due.fitness);
        if (m_axis_tuser !== due.gen_done)
          report_mismatch("generation_done", m_axis_tuser, due.gen_done);
        if (m_axis_tdata[BIDX_LSB +: IDX_W] !== due.best_idx)
          report_mismatch("best_index", m_axis_tdata[BIDX_LSB +: IDX_W], due.best_idx);
        if (m_axis_tdata[SIDX_LSB +: IDX_W] !== due.second_idx)
          report_mismatch("second_index", m_axis_tdata[SIDX_LSB +: IDX_W], due.second_idx);
        if (m_axis_tdata[BFIT_LSB +: FIT_W] !== due.best_fit)
          report_mismatch("best_fitness", m_axis_tdata[BFIT_LSB +: FIT_W], due.best_fit);
        if (m_axis_tdata[STAG_BIT] !== due.stagnant)
          report_mismatch("stagnant", m_axis_tdata[STAG_BIT], due.stagnant);
        if (m_axis_tdata[OUT_TDATA_W-1:STAG_BIT+1] !== '0)
          report_mismatch("pad bits", m_axis_tdata[OUT_TDATA_W-1:STAG_BIT+1], 64'd0);
      end
      results_seen++;
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[colville_fitness_top_two_select_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, single-item generations, ties and a late new best
  task automatic test_directed_corners();
    set_traffic(3, 4, 16'hB6DB);
    send_chromosome(64'h0, 1'b1);                        // one-item generation
    send_chromosome('1, 1'b1);
    send_chromosome(OPT_CHROM, 1'b0);                    // zero fitness
    send_chromosome(OPT_CHROM, 1'b0);                    // tie keeps first seen
    send_chromosome(64'h0, 1'b0);
    send_chromosome('1, 1'b1);
    send_chromosome('1, 1'b0);
    send_chromosome(64'h8000_8000_8000_8000, 1'b0);      // all fields zero
    send_chromosome(OPT_CHROM, 1'b0);                    // best replaced late
    send_chromosome(64'h8401_8400_8400_8400, 1'b1);      // runner replaced
    send_chromosome(64'hAAAA_5555_AAAA_5555, 1'b0);
    send_chromosome(64'h5555_AAAA_5555_AAAA, 1'b0);
    send_chromosome(64'h8400_8400_0000_FFFF, 1'b1);
    wait_all_results();
  endtask

  // Zero threshold never flags, full-scale threshold flags any real gap
  task automatic test_threshold_limits();
    write_threshold('0);
    set_traffic(2, 2, '1);
    send_chromosome(OPT_CHROM, 1'b0);
    send_chromosome(OPT_CHROM, 1'b1);
    send_chromosome(OPT_CHROM, 1'b1);
    wait_all_results();
    write_threshold(FIT_MASK);
    send_chromosome('1, 1'b0);
    send_chromosome(OPT_CHROM, 1'b1);
    wait_all_results();
  endtask

  // Random generations of random length under the given threshold and idling
  task automatic test_random_generations(input logic [FIT_W-1:0] thr, input int gmax,
                                         input int bmax, input logic [15:0] mask);
    int sent;
    int glen;
    int flavor;
    sent = 0;
    write_threshold(thr);
    set_traffic(gmax, bmax, mask);
    while (sent < RANDOM_ITEMS) begin
      glen   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
      flavor = $urandom_range(0, 2);
      for (int i = 0; i < glen; i++) begin
        send_chromosome(rand_chromosome(flavor), i == glen - 1);
      end
      sent += glen;
    end
    wait_all_results();
  endtask

  // Hold the output off while offering back-to-back items; the block must
  // fill up and stall its input, then drain cleanly.
  task automatic test_output_backpressure();
    set_traffic(0, 64, '1);
    -> hold_off_ev;
    for (int i = 0; i < 16; i++) begin
      send_chromosome(rand_chromosome(1), i == 7 || i == 15);
    end
    wait_all_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_threshold_limits();
    test_random_generations(THRESH_RST, 0, 32, '1);
    test_random_generations(FIT_W'($urandom_range(0, 5000)), 20, 6, 16'($urandom) | 16'h1);
    test_random_generations(FIT_W'({$urandom, $urandom}), 40, 3,
                            16'($urandom & $urandom) | 16'h1);
    test_random_generations(FIT_W'($urandom_range(0, 1 << 24)), 8, 12,
                            16'($urandom) | 16'h8001);
    test_random_generations(FIT_MASK, 5, 4, 16'hF0F1);
    test_output_backpressure();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && results_due.size() == 0) begin
      $display("[colville_fitness_top_two_select_top] OK");
    end else begin
      $display("[colville_fitness_top_two_select_top] ERROR");
    end
    $finish;
  end

endmodule
